// ===== sv/lps_pkg.sv =====
`default_nettype none
package lps_pkg;

  // Pattern selected by the program buttons
  typedef enum logic [2:0] {
    MODE_NONE     = 3'd0,
    MODE_TOGGLE   = 3'd1,
    MODE_WALK     = 3'd2,
    MODE_CONVERGE = 3'd3,
    MODE_FILL     = 3'd4
  } mode_t;

  // LED and mask constants of the walk, converging and fill patterns
  localparam logic [7:0] LED_CLEAR     = 8'h00;
  localparam logic [7:0] LED_FIRST     = 8'h01;
  localparam logic [7:0] LED_LAST      = 8'h80;
  localparam logic [7:0] MASK_LOW_INIT  = 8'h01;
  localparam logic [7:0] MASK_HIGH_INIT = 8'h80;
  localparam logic [7:0] FILL_INIT      = 8'h40;
  localparam logic [7:0] CONV_CENTER    = 8'h10;
  localparam logic [7:0] CONV_LOW_WRAP  = 8'h02;
  localparam logic [7:0] CONV_HIGH_WRAP = 8'h40;
  localparam logic [7:0] FILL_FULL      = 8'h1F;

  // One pass of buttons, all active low
  typedef struct packed {
    logic start_n;
    logic stop_n;
    logic prog_one_n;
    logic prog_two_n;
    logic prog_three_n;
    logic prog_four_n;
    logic fast_n;
    logic slow_n;
  } lps_in_t;

  // Result of one pass
  typedef struct packed {
    logic [7:0] led_out;
    logic       is_running;
    logic       long_dwell;
  } lps_out_t;

  // Sequencer state carried from pass to pass
  typedef struct packed {
    logic       run_flag;
    logic       speed_sel;
    mode_t      pattern_mode;
    logic [7:0] led_reg;
    logic [7:0] low_mask;
    logic [7:0] high_mask;
    logic [7:0] fill_bit;
    logic       reverse_flag;
  } lps_state_t;

endpackage
`default_nettype wire

// ===== sv/lps_step.sv =====
`default_nettype none
module lps_step (
  input  lps_pkg::lps_in_t    item,
  input  lps_pkg::lps_state_t cur,
  output lps_pkg::lps_state_t nxt,
  output lps_pkg::lps_out_t   res
);
  import lps_pkg::*;

  // Advance the sequencer by one pass
  always_comb begin
    lps_state_t s;
    logic       run;
    s = cur;
    run = cur.run_flag;
    if (!item.start_n) run = 1'b1;
    if (!item.stop_n) run = 1'b0;
    s.run_flag = run;
    res.led_out = cur.led_reg;
    res.is_running = 1'b0;
    res.long_dwell = 1'b0;

    if (run) begin
      // pick dwell, fast wins
      if (!item.fast_n) begin
        s.speed_sel = 1'b0;
      end else if (!item.slow_n) begin
        s.speed_sel = 1'b1;
      end

      // program select, highest button wins
      if (!item.prog_four_n) begin
        s.pattern_mode = MODE_FILL;
        s.led_reg = LED_CLEAR;
        s.reverse_flag = 1'b0;
        s.fill_bit = FILL_INIT;
        s.low_mask = MASK_LOW_INIT;
        s.high_mask = MASK_HIGH_INIT;
      end else if (!item.prog_three_n) begin
        s.pattern_mode = MODE_CONVERGE;
        s.low_mask = MASK_LOW_INIT;
        s.high_mask = MASK_HIGH_INIT;
        s.led_reg = LED_CLEAR;
      end else if (!item.prog_two_n) begin
        s.pattern_mode = MODE_WALK;
        s.led_reg = LED_CLEAR;
      end else if (!item.prog_one_n) begin
        s.pattern_mode = MODE_TOGGLE;
        s.led_reg = LED_CLEAR;
      end

      // step the selected pattern
      case (s.pattern_mode)
        MODE_TOGGLE: begin
          s.led_reg = ~s.led_reg;
        end
        MODE_WALK: begin
          if (s.led_reg == LED_CLEAR || s.led_reg[7]) begin
            s.led_reg = LED_FIRST;
          end else begin
            s.led_reg = s.led_reg << 1;
          end
        end
        MODE_CONVERGE: begin
          // skip the center pair
          if (s.low_mask == CONV_CENTER) begin
            s.low_mask = s.low_mask << 1;
            s.high_mask = s.high_mask >> 1;
          end
          s.led_reg = s.low_mask | s.high_mask;
          s.low_mask = s.low_mask << 1;
          s.high_mask = s.high_mask >> 1;
          if (s.low_mask == LED_CLEAR) begin
            s.low_mask = CONV_LOW_WRAP;
            s.high_mask = CONV_HIGH_WRAP;
          end
        end
        MODE_FILL: begin
          if (s.low_mask == LED_CLEAR) begin
            // restart after fully emptied
            s.high_mask = MASK_HIGH_INIT;
            s.fill_bit = FILL_INIT;
            s.low_mask = MASK_LOW_INIT;
            s.led_reg = LED_CLEAR;
            s.reverse_flag = 1'b0;
          end else begin
            if (s.low_mask == FILL_FULL) begin
              s.reverse_flag = 1'b1;
              s.high_mask = s.high_mask << 2;
              s.low_mask = s.low_mask >> 2;
            end
            s.led_reg = s.low_mask | s.high_mask;
            if (!s.reverse_flag) begin
              s.low_mask = (s.low_mask << 1) + 8'd1;
              s.high_mask = s.high_mask | s.fill_bit;
              s.fill_bit = s.fill_bit >> 1;
            end else begin
              s.low_mask = s.low_mask >> 1;
              s.high_mask = s.high_mask << 1;
            end
          end
        end
        default: begin
          // no pattern: hold LEDs
        end
      endcase

      res.led_out = s.led_reg;
      res.is_running = 1'b1;
      res.long_dwell = s.speed_sel;
    end
    nxt = s;
  end

endmodule
`default_nettype wire

// ===== sv/led_pattern_sequencer.sv =====
// LED pattern sequencer.
// Each input item is one pass of eight active-low buttons (start, stop,
// four program selects, fast, slow); each pass yields exactly one result
// item with the LED byte, the running flag and the dwell flag.
// Both channels are valid/ready. An item is captured in an input
// register, processed against the sequencer state once the output
// register has room, and the result lands there and raises out_valid.
// Throughput is one item per cycle while out_ready stays high; the
// only loop is the update of the sequencer state registers.
// If the receiver stalls, the result is held in the output register and
// one more item waits in the input register; in_ready then drops until
// out_ready returns.
// Reset stops the sequencer, clears the LEDs, masks and pattern select,
// and empties both registers.
`default_nettype none
module led_pattern_sequencer (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  lps_pkg::lps_in_t in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output lps_pkg::lps_out_t out_data
);
  import lps_pkg::*;

  lps_in_t    in_q;
  logic       in_full;
  lps_state_t state;
  lps_state_t state_next;
  lps_out_t   res;
  logic       advance;

  // Move the held item into the result register when there is room
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  lps_step u_step (
    .item (in_q),
    .cur  (state),
    .nxt  (state_next),
    .res  (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  // Sequencer state, updated once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{run_flag: 1'b0, speed_sel: 1'b0, pattern_mode: MODE_NONE,
                 led_reg: 8'h00, low_mask: 8'h00, high_mask: 8'h00,
                 fill_bit: 8'h00, reverse_flag: 1'b0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire
